// ===== design/bstw_pkg.sv =====
package bstw_pkg;

   // parser phases
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   // header byte positions (little-endian fields)
   localparam logic [15:0] HDR_OFS_LO = 16'd10;
   localparam logic [15:0] HDR_OFS_HI = 16'd11;
   localparam logic [15:0] HDR_WID_LO = 16'd18;
   localparam logic [15:0] HDR_WID_HI = 16'd19;
   localparam logic [15:0] HDR_HGT_LO = 16'd22;
   localparam logic [15:0] HDR_HGT_HI = 16'd23;
   localparam logic [15:0] HDR_LAST   = 16'd28;
   localparam logic [15:0] HDR_FIRST_PIXEL = 16'd29;

   localparam logic [7:0] DARK_RESET = 8'd215;

   // configuration port
   localparam int ADDR_W = 3;
   localparam logic REG_DARK_LEVEL = 1'b0;

   // pixel queue between parser and threshold stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [15:0] row;
      logic [15:0] col;
      logic [12:0] sum;
      logic [4:0]  bpp;
      logic        last;
   } pixel_rec_type;

endpackage

// ===== design/bstw_if.sv =====
interface bstw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bstw_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_row;
   logic [15:0] pixel_col;
   logic        is_wall;
   logic        last_pixel;

   modport source (output valid, output pixel_row, output pixel_col, output is_wall,
                   output last_pixel, input ready);
   modport sink (input valid, input pixel_row, input pixel_col, input is_wall,
                 input last_pixel, output ready);
endinterface

// ===== design/bstw_front.sv =====
module bstw_front (
   input  logic                   clock,
   input  logic                   reset,
   bstw_req_if.sink               req_chan,
   input  logic                   queue_full,
   output logic                   push,
   output bstw_pkg::pixel_rec_type push_rec
);

   bstw_pkg::phase_type phase_ff, phase_in, ph;
   logic [15:0] byte_idx_ff, byte_idx_in, idx;
   logic [15:0] offset_ff, offset_in, ofs;
   logic [15:0] width_ff, width_in, wid;
   logic [15:0] height_ff, height_in, hgt;
   logic [4:0]  bpp_ff, bpp_in, bpp;
   logic [1:0]  row_pad_ff, row_pad_in, rpad;
   logic [15:0] row_ff, row_in, row;
   logic [15:0] col_ff, col_in, col;
   logic [4:0]  chan_ff, chan_in, chan;
   logic [1:0]  pad_ff, pad_in, pad;
   logic [12:0] sum_ff, sum_in, sum;

   logic        fire;
   logic        first;
   logic [7:0]  b;
   logic [12:0] sum_next;
   logic [4:0]  chan_next;
   logic        pix_done;
   logic        line_end;
   logic [3:0]  pad_prod;

   assign req_chan.ready = !queue_full;
   assign fire  = req_chan.valid && !queue_full;
   assign first = req_chan.first_byte;
   assign b     = req_chan.data_byte;

   // a start mark sees the cleared parse state
   assign ph   = first ? bstw_pkg::PH_HEADER : phase_ff;
   assign idx  = first ? 16'd0 : byte_idx_ff;
   assign ofs  = first ? 16'd0 : offset_ff;
   assign wid  = first ? 16'd0 : width_ff;
   assign hgt  = first ? 16'd0 : height_ff;
   assign bpp  = first ? 5'd0 : bpp_ff;
   assign rpad = first ? 2'd0 : row_pad_ff;
   assign row  = first ? 16'd0 : row_ff;
   assign col  = first ? 16'd0 : col_ff;
   assign chan = first ? 5'd0 : chan_ff;
   assign pad  = first ? 2'd0 : pad_ff;
   assign sum  = first ? 13'd0 : sum_ff;

   assign sum_next  = sum + 13'(b);
   assign chan_next = chan + 5'd1;
   assign pix_done  = (ph == bstw_pkg::PH_PIXELS) && (pad == 2'd0) && (chan_next == bpp);
   assign line_end  = ({1'b0, col} + 17'd1) == {1'b0, wid};

   // next state
   always_comb begin
      phase_in    = ph;
      byte_idx_in = idx;
      offset_in   = ofs;
      width_in    = wid;
      height_in   = hgt;
      bpp_in      = bpp;
      row_pad_in  = rpad;
      row_in      = row;
      col_in      = col;
      chan_in     = chan;
      pad_in      = pad;
      sum_in      = sum;
      pad_prod    = 4'd0;
      unique case (ph)
         bstw_pkg::PH_HEADER: begin
            case (idx)
               bstw_pkg::HDR_OFS_LO: offset_in = {ofs[15:8], b};
               bstw_pkg::HDR_OFS_HI: offset_in = {b, ofs[7:0]};
               bstw_pkg::HDR_WID_LO: width_in  = {wid[15:8], b};
               bstw_pkg::HDR_WID_HI: width_in  = {b, wid[7:0]};
               bstw_pkg::HDR_HGT_LO: height_in = {hgt[15:8], b};
               bstw_pkg::HDR_HGT_HI: height_in = {b, hgt[7:0]};
               bstw_pkg::HDR_LAST:   bpp_in    = b[7:3];
               default: ;
            endcase
            if (idx == bstw_pkg::HDR_LAST) begin
               // padding brings each stored line to a multiple of 4 bytes
               pad_prod   = 4'(width_in[1:0]) * 4'(bpp_in[1:0]);
               row_pad_in = 2'd0 - pad_prod[1:0];
               row_in     = height_in - 16'd1;
               col_in     = 16'd0;
               chan_in    = 5'd0;
               sum_in     = 13'd0;
               pad_in     = 2'd0;
               if (bpp_in == 5'd0 || offset_in < bstw_pkg::HDR_FIRST_PIXEL ||
                   width_in == 16'd0 || height_in == 16'd0) begin
                  phase_in = bstw_pkg::PH_DONE;
               end else if (offset_in == bstw_pkg::HDR_FIRST_PIXEL) begin
                  phase_in = bstw_pkg::PH_PIXELS;
               end else begin
                  phase_in = bstw_pkg::PH_SKIP;
               end
            end
            byte_idx_in = idx + 16'd1;
         end
         bstw_pkg::PH_SKIP: begin
            if (idx < ofs) begin
               byte_idx_in = idx + 16'd1;
               if (byte_idx_in == ofs) begin
                  phase_in = bstw_pkg::PH_PIXELS;
               end
            end
         end
         bstw_pkg::PH_PIXELS: begin
            if (pad != 2'd0) begin
               pad_in = pad - 2'd1;
            end else if (pix_done) begin
               chan_in = 5'd0;
               sum_in  = 13'd0;
               if (line_end) begin
                  col_in = 16'd0;
                  pad_in = rpad;
                  if (row == 16'd0) begin
                     phase_in = bstw_pkg::PH_DONE;
                  end else begin
                     row_in = row - 16'd1;
                  end
               end else begin
                  col_in = col + 16'd1;
               end
            end else begin
               chan_in = chan_next;
               sum_in  = sum_next;
            end
         end
         bstw_pkg::PH_DONE: ;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      push          = fire && pix_done;
      push_rec.row  = row;
      push_rec.col  = col;
      push_rec.sum  = sum_next;
      push_rec.bpp  = bpp;
      push_rec.last = (row == 16'd0) && line_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bstw_pkg::PH_HEADER;
         byte_idx_ff <= '0;
         offset_ff   <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         bpp_ff      <= '0;
         row_pad_ff  <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         chan_ff     <= '0;
         pad_ff      <= '0;
         sum_ff      <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         byte_idx_ff <= byte_idx_in;
         offset_ff   <= offset_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         bpp_ff      <= bpp_in;
         row_pad_ff  <= row_pad_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         chan_ff     <= chan_in;
         pad_ff      <= pad_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

// ===== design/bstw_queue.sv =====
module bstw_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bstw_pkg::pixel_rec_type push_rec,
   output logic                    full,
   input  logic                    pop,
   output bstw_pkg::pixel_rec_type pop_rec,
   output logic                    not_empty
);

   bstw_pkg::pixel_rec_type         entry_ff [bstw_pkg::QUEUE_DEPTH];
   logic [bstw_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bstw_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign full      = count_ff == (bstw_pkg::QUEUE_PTR_W+1)'(bstw_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_rec   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (bstw_pkg::QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (bstw_pkg::QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + (bstw_pkg::QUEUE_PTR_W)'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + (bstw_pkg::QUEUE_PTR_W)'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/bstw_back.sv =====
module bstw_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              dark_level,
   input  logic                    avail,
   input  bstw_pkg::pixel_rec_type rec,
   output logic                    pop,
   bstw_rsp_if.source              rsp_chan
);

   logic        out_valid_ff;
   logic [15:0] row_ff, col_ff;
   logic        wall_ff, last_ff;
   logic [12:0] threshold;
   logic        load;

   // wall when the channel sum is below dark_level per channel
   assign threshold = 13'(dark_level) * 13'(rec.bpp);
   assign load      = avail && (!out_valid_ff || rsp_chan.ready);
   assign pop       = load;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_row  = row_ff;
   assign rsp_chan.pixel_col  = col_ff;
   assign rsp_chan.is_wall    = wall_ff;
   assign rsp_chan.last_pixel = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff  <= rec.row;
         col_ff  <= rec.col;
         wall_ff <= rec.sum < threshold;
         last_ff <= rec.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

// ===== design/bmp_stream_threshold_to_wall_map.sv =====
// bmp byte stream to wall map: one file byte accepted per cycle while results drain
// a pixel's result passes through the queue entry, written at the edge that accepts its
// last byte, and then the output register before it can be taken from rsp
// rate is set by the parser, which updates its counters once per byte
// reset (synchronous, active high): parser back to header byte 0, queue and
// output emptied, dark_level back to 215
module bmp_stream_threshold_to_wall_map (
   input  logic                         clock,
   input  logic                         reset,
   bstw_req_if.sink                     req_chan,
   bstw_rsp_if.source                   rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bstw_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   logic [7:0]              dark_ff;
   logic                    csr_write;
   logic                    queue_full;
   logic                    queue_push;
   logic                    queue_pop;
   logic                    queue_avail;
   bstw_pkg::pixel_rec_type push_rec;
   bstw_pkg::pixel_rec_type pop_rec;

   // config register: dark level, one 32-bit word per register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == bstw_pkg::REG_DARK_LEVEL) ? {24'd0, dark_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff <= bstw_pkg::DARK_RESET;
      end else if (csr_write && paddr[2] == bstw_pkg::REG_DARK_LEVEL) begin
         dark_ff <= pwdata[7:0];
      end
   end

   // front: header parse, offset skip, per-pixel byte sums
   bstw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (queue_push),
      .push_rec   (push_rec)
   );

   // short queue of finished pixel sums
   bstw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_rec   (pop_rec),
      .not_empty (queue_avail)
   );

   // back: threshold compare and output register
   bstw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dark_level (dark_ff),
      .avail      (queue_avail),
      .rec        (pop_rec),
      .pop        (queue_pop),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   // the parser never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) queue_push |-> !queue_full)
      else $error("pixel pushed into full queue");

   // the back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) queue_pop |-> queue_avail)
      else $error("pixel popped from empty queue");

   // reset leaves no result pending and the default dark level
   assert property (@(posedge clock) reset |=> (!rsp_chan.valid && dark_ff == bstw_pkg::DARK_RESET))
      else $error("state not cleared by reset");
`endif

endmodule
